@@ design/lzss_window_decoder_macros.svh @@
// ----------------------------------------------------------------------------
// lzss_window_decoder_macros.svh
// Assertion macros shared by the LZSS window decoder modules.
// ----------------------------------------------------------------------------
`ifndef LZSS_WINDOW_DECODER_MACROS_SVH
`define LZSS_WINDOW_DECODER_MACROS_SVH

// Plain clocked property, off during reset.
`define LWD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Cause in this cycle, expected effect in the cycle after.
`define LWD_ASSERT_NEXT(name, cause, effect, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error(msg);

`endif

@@ design/lwd_pkg.sv @@
// ----------------------------------------------------------------------------
// lwd_pkg
// Shared constants and types of the LZSS window decoder.
// ----------------------------------------------------------------------------
package lwd_pkg;

    localparam int WINDOW_SIZE_DEF = 4096;
    localparam int MAX_MATCH       = 18;
    localparam int MIN_MATCH       = 3;

    // flag byte handling
    localparam logic [15:0] FLAG_FILL     = 16'hff00;
    localparam int          FLAG_MARK_BIT = 8;       // bit of 0x100: flags remain
    localparam logic [7:0]  HI_NIBBLE     = 8'hf0;
    localparam logic [7:0]  LEN_NIBBLE    = 8'h0f;

    // window control from the sequencer
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic clear;
    } lwd_win_ctl_t;

endpackage

@@ design/lwd_in_if.sv @@
// ----------------------------------------------------------------------------
// lwd_in_if
// Compressed byte channel: valid/ready with one stream byte per transfer.
// ----------------------------------------------------------------------------
interface lwd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

@@ design/lwd_out_if.sv @@
// ----------------------------------------------------------------------------
// lwd_out_if
// Decoded byte channel: valid/ready with one output byte per transfer.
// ----------------------------------------------------------------------------
interface lwd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

@@ design/lwd_window.sv @@
// ----------------------------------------------------------------------------
// lwd_window
// Ring window memory with a fill count; unwritten entries read as zero.
// ----------------------------------------------------------------------------
`include "lzss_window_decoder_macros.svh"

module lwd_window
    import lwd_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  lwd_win_ctl_t                   ctl,
    input  logic [$clog2(WINDOW_SIZE)-1:0] wr_addr,
    input  logic [7:0]                     wr_data,
    input  logic [$clog2(WINDOW_SIZE)-1:0] rd_addr,
    output logic [7:0]                     rd_data
);

    localparam int                ADDR_W    = $clog2(WINDOW_SIZE);
    localparam logic [ADDR_W-1:0] START_POS = ADDR_W'(WINDOW_SIZE - MAX_MATCH);
    localparam logic [ADDR_W:0]   FILL_FULL = (ADDR_W+1)'(WINDOW_SIZE);

    logic [7:0]        mem [WINDOW_SIZE];
    logic [7:0]        rdata_reg;
    logic              hit_reg;
    logic              hit_next;
    logic [ADDR_W:0]   fill_reg;
    logic [ADDR_W:0]   fill_next;
    logic [ADDR_W-1:0] rd_off;

    // writes run in order from START_POS, so written entries form one arc
    assign rd_off   = rd_addr - START_POS;
    assign hit_next = {1'b0, rd_off} < fill_reg;

    always_comb
    begin
        fill_next = fill_reg;
        if (ctl.clear)
        begin
            fill_next = '0;
        end
        else if (ctl.wr_en && (fill_reg != FILL_FULL))
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (ctl.rd_en)
            begin
                hit_reg <= hit_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign rd_data = hit_reg ? rdata_reg : 8'h00;

    `LWD_ASSERT(a_fill_bound, fill_reg <= FILL_FULL, "window fill count overran")
    `LWD_ASSERT_NEXT(a_clear_empties, ctl.clear, fill_reg == '0, "clear left entries valid")

endmodule

@@ design/lzss_window_decoder.sv @@
// ----------------------------------------------------------------------------
// lzss_window_decoder
// LZSS decoder over a ring window: flag bytes, literals and window copies.
// ----------------------------------------------------------------------------
//  channel   dir   payload                      transfer
//  coded     in    in_byte, end_of_stream       valid & ready
//  decoded   out   out_byte, last_of_run        valid & ready
//
//  Flag bytes, literals and first match bytes are each one S_IDLE transfer.
//  A match of length L (3..18 bytes) then runs the copy loop:
//  each copied byte is an S_READ window read, then an S_EMIT emit/write-back.
//  The output register holds one byte; a stalled sink stalls the copy loop.
//  Reset or end_of_stream restarts the stream; the window reads as zero
//  again at once (fill count), no clearing pass.
// ----------------------------------------------------------------------------
`include "lzss_window_decoder_macros.svh"

module lzss_window_decoder
    import lwd_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    lwd_in_if.sink    coded,
    lwd_out_if.source decoded
);

    localparam int                ADDR_W    = $clog2(WINDOW_SIZE);
    localparam logic [ADDR_W-1:0] START_POS = ADDR_W'(WINDOW_SIZE - MAX_MATCH);

    // parse phase codes
    localparam logic [1:0] PH_FLAG  = 2'd0;
    localparam logic [1:0] PH_TOKEN = 2'd1;
    localparam logic [1:0] PH_MATCH = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [15:0]       flag_reg, flag_next;
    logic [7:0]        low_reg, low_next;
    logic [ADDR_W-1:0] wp_reg, wp_next;     // window write position
    logic [ADDR_W-1:0] rp_reg, rp_next;     // copy read position
    logic [4:0]        cnt_reg, cnt_next;   // copy bytes left minus one
    logic              eos_reg, eos_next;
    logic              ov_reg, ov_next;
    logic [7:0]        ob_reg, ob_next;
    logic              last_reg, last_next;

    logic              can_load;
    logic              in_xfer;
    logic [15:0]       flag_shifted;
    logic [1:0]        phase_after;
    logic [11:0]       match_pos;
    lwd_win_ctl_t      win_ctl;
    logic [7:0]        win_wdata;
    logic [7:0]        win_rdata;

    assign can_load     = !ov_reg || decoded.ready;
    assign coded.ready  = (state_reg == S_IDLE) && can_load;
    assign in_xfer      = coded.valid && coded.ready;
    assign flag_shifted = flag_reg >> 1;
    assign phase_after  = flag_shifted[FLAG_MARK_BIT] ? PH_TOKEN : PH_FLAG;
    assign match_pos    = (12'(coded.in_byte & HI_NIBBLE) << 4) | 12'(low_reg);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        flag_next  = flag_reg;
        low_next   = low_reg;
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        cnt_next   = cnt_reg;
        eos_next   = eos_reg;
        ov_next    = ov_reg && !decoded.ready;
        ob_next    = ob_reg;
        last_next  = last_reg;
        win_ctl    = '0;
        win_wdata  = ob_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    unique case (phase_reg)
                        PH_TOKEN:
                        begin
                            if (flag_reg[0])
                            begin
                                // literal: emit and store
                                ob_next        = coded.in_byte;
                                last_next      = 1'b1;
                                ov_next        = 1'b1;
                                win_ctl.wr_en  = 1'b1;
                                win_wdata      = coded.in_byte;
                                wp_next        = wp_reg + 1'b1;
                                flag_next      = flag_shifted;
                                phase_next     = phase_after;
                            end
                            else
                            begin
                                low_next   = coded.in_byte;
                                phase_next = PH_MATCH;
                            end
                        end
                        PH_MATCH:
                        begin
                            rp_next    = match_pos[ADDR_W-1:0];
                            cnt_next   = 5'(coded.in_byte & LEN_NIBBLE) + 5'(MIN_MATCH - 1);
                            eos_next   = coded.end_of_stream;
                            state_next = S_READ;
                        end
                        default:
                        begin
                            // flag byte; unused phase code lands here too
                            flag_next  = FLAG_FILL | 16'(coded.in_byte);
                            phase_next = PH_TOKEN;
                        end
                    endcase

                    // stream end outside a copy: restart now
                    if (coded.end_of_stream && (phase_reg != PH_MATCH))
                    begin
                        wp_next       = START_POS;
                        flag_next     = '0;
                        low_next      = '0;
                        phase_next    = PH_FLAG;
                        win_ctl.clear = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                win_ctl.rd_en = 1'b1;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                if (can_load)
                begin
                    ob_next       = win_rdata;
                    last_next     = (cnt_reg == '0);
                    ov_next       = 1'b1;
                    win_ctl.wr_en = 1'b1;
                    win_wdata     = win_rdata;
                    wp_next       = wp_reg + 1'b1;
                    rp_next       = rp_reg + 1'b1;
                    if (cnt_reg == '0)
                    begin
                        flag_next  = flag_shifted;
                        phase_next = phase_after;
                        state_next = S_IDLE;
                        if (eos_reg)
                        begin
                            wp_next       = START_POS;
                            flag_next     = '0;
                            low_next      = '0;
                            phase_next    = PH_FLAG;
                            win_ctl.clear = 1'b1;
                        end
                    end
                    else
                    begin
                        cnt_next   = cnt_reg - 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_FLAG;
            flag_reg  <= '0;
            low_reg   <= '0;
            wp_reg    <= START_POS;
            cnt_reg   <= '0;
            eos_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            flag_reg  <= flag_next;
            low_reg   <= low_next;
            wp_reg    <= wp_next;
            cnt_reg   <= cnt_next;
            eos_reg   <= eos_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rp_reg   <= rp_next;
        ob_reg   <= ob_next;
        last_reg <= last_next;
    end

    lwd_window #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (win_ctl),
        .wr_addr (wp_reg),
        .wr_data (win_wdata),
        .rd_addr (rp_reg),
        .rd_data (win_rdata)
    );

    assign decoded.valid       = ov_reg;
    assign decoded.out_byte    = ob_reg;
    assign decoded.last_of_run = last_reg;

    `LWD_ASSERT_NEXT(a_read_then_emit, state_reg == S_READ, state_reg == S_EMIT,
        "window read not followed by emit")
    `LWD_ASSERT_NEXT(a_copy_end, (state_reg == S_EMIT) && can_load && (cnt_reg == '0),
        ov_reg && last_reg && (state_reg == S_IDLE), "copy end not marked last")
    `LWD_ASSERT_NEXT(a_eos_restart,
        in_xfer && coded.end_of_stream && (phase_reg != PH_MATCH),
        (phase_reg == PH_FLAG) && (wp_reg == START_POS) && (flag_reg == '0),
        "end of stream did not restart decoder")

endmodule
